// ===== sv/assert_macros.svh =====
// assert_macros.svh: concurrent assertion macros shared by the checkers.
// Depends on nothing; each macro expects a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define AST_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// Next-cycle implication, disabled while reset is low
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

// ===== sv/tplu_pkg.sv =====
// tplu_pkg: word types, entry layout, codes and constants of the torsion lookup.
// Depends on nothing; used by every module of the block.
package tplu_pkg;

    localparam int ATOM_W      = 16;
    localparam int BOND_BITS   = 4;
    localparam int BOND_W      = 3 * BOND_BITS;
    localparam int FORCE_W     = 32;
    localparam int SLOT_W      = 8;
    localparam int SLOT_COUNT  = 1 << SLOT_W;
    localparam int COUNT_W     = 9;

    localparam logic [ATOM_W-1:0] WILDCARD_TYPE = 16'hffff;

    // Item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Input word
    typedef struct packed {
        logic               func;
        logic [SLOT_W-1:0]  entry_slot;
        logic [ATOM_W-1:0]  type_a;
        logic [ATOM_W-1:0]  type_b;
        logic [ATOM_W-1:0]  type_c;
        logic [ATOM_W-1:0]  type_d;
        logic [BOND_W-1:0]  bond_kinds;
        logic [FORCE_W-1:0] force_one;
        logic [FORCE_W-1:0] force_two;
        logic [FORCE_W-1:0] force_three;
        logic               strict_match;
    } t_query_word;

    // Result word
    typedef struct packed {
        logic               found;
        logic [SLOT_W-1:0]  match_slot;
        logic               reversed;
        logic [FORCE_W-1:0] out_force_one;
        logic [FORCE_W-1:0] out_force_two;
        logic [FORCE_W-1:0] out_force_three;
    } t_result_word;

    // Match key: atoms and bond codes, as stored and as queried
    typedef struct packed {
        logic [ATOM_W-1:0] atom_d;
        logic [ATOM_W-1:0] atom_c;
        logic [ATOM_W-1:0] atom_b;
        logic [ATOM_W-1:0] atom_a;
        logic [BOND_W-1:0] bonds;
    } t_key;

    // One table entry
    typedef struct packed {
        t_key               key;
        logic [FORCE_W-1:0] force_three;
        logic [FORCE_W-1:0] force_two;
        logic [FORCE_W-1:0] force_one;
    } t_entry;

    // Matcher status toward the scan control
    typedef struct packed {
        logic hit;
        logic reversed;
    } t_match_status;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_scan_state;

    // Bond code at position pos (0 first, 1 middle, 2 third)
    function automatic logic [BOND_BITS-1:0] bond_code(input logic [BOND_W-1:0] packed_bonds,
                                                       input int unsigned pos);
        return packed_bonds[pos*BOND_BITS +: BOND_BITS];
    endfunction

endpackage

// ===== sv/torsion_param_lookup_unit.sv =====
// Torsion parameter lookup. A write word loads one table entry and gives no
// result. A query word scans entries 0 .. min(entry_count, TABLE_DEPTH)-1
// through the one read port of the entry memory, one entry per cycle, and
// stops at the first match. busy rises the cycle after a query with a non-empty
// range is taken; each entry is read through the registered read port and
// compared, then result and strobe are registered; an empty range answers in
// the next cycle. The strobe is high for a single cycle, the result word holds
// until the next query, and the receiver cannot stall. The user must write
// entry_count only while idle; the block does not enforce it. Entries read before being written return undefined data.
// Depends on tplu_pkg, tplu_table_ram and tplu_match.
module torsion_param_lookup_unit
    import tplu_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_query_word        i_item,
    output logic               o_strobe,
    output t_result_word       o_result,
    input  logic               i_cfg_wr_en,
    input  logic [COUNT_W-1:0] i_cfg_wr_data
);

    localparam int AW      = $clog2(TABLE_DEPTH);
    localparam int DEPTH_W = $clog2(TABLE_DEPTH + 1);
    localparam int LW      = (DEPTH_W > COUNT_W) ? DEPTH_W : COUNT_W;

    t_scan_state        r_state, n_state;
    logic [COUNT_W-1:0] r_entry_count;
    t_key               r_key;
    logic               r_strict;
    logic [AW-1:0]      r_ptr;
    logic [AW-1:0]      r_last_idx;
    logic               r_issue_on;
    logic               r_rvalid;
    logic               r_rlast;
    logic [AW-1:0]      r_ridx;
    logic               r_strobe;
    t_result_word       r_result;

    logic               accept;
    logic               wr_en;
    logic               query_go;
    logic [LW-1:0]      limit;
    logic               rd_en;
    logic               done;
    t_entry             wr_data;
    t_entry             rd_data;
    t_key               query_key;
    t_match_status      status;
    logic [AW-1:0]      slot_wrap [SLOT_COUNT];

    // Slot wraps modulo the table depth: constant table
    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_slot
        localparam int SlotMod = g % TABLE_DEPTH;
        assign slot_wrap[g] = AW'(SlotMod);
    end

    // Handshake decode
    assign accept   = start && !busy;
    assign wr_en    = accept && (i_item.func == FUNC_WRITE);
    assign query_go = accept && (i_item.func == FUNC_QUERY);
    assign limit    = (LW'(r_entry_count) > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH)
                                                              : LW'(r_entry_count);

    assign query_key.atom_a = i_item.type_a;
    assign query_key.atom_b = i_item.type_b;
    assign query_key.atom_c = i_item.type_c;
    assign query_key.atom_d = i_item.type_d;
    assign query_key.bonds  = i_item.bond_kinds;

    assign wr_data.key         = query_key;
    assign wr_data.force_one   = i_item.force_one;
    assign wr_data.force_two   = i_item.force_two;
    assign wr_data.force_three = i_item.force_three;

    // Writes only happen while idle and reads only while scanning, so a read
    // never overlaps a write to the same entry.
    tplu_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (slot_wrap[i_item.entry_slot]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_ptr),
        .o_rd_data (rd_data)
    );

    tplu_match u_match (
        .i_entry  (rd_data.key),
        .i_query  (r_key),
        .i_strict (r_strict),
        .o_status (status)
    );

    // Scan ends on a hit or after the last entry is compared
    assign done = r_rvalid && (status.hit || r_rlast);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (query_go && (limit != '0)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        busy  = 1'b0;
        rd_en = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                busy  = 1'b0;
                rd_en = 1'b0;
            end
            ST_SCAN: begin
                busy  = 1'b1;
                rd_en = r_issue_on;
            end
            default: begin
                busy  = 1'b0;
                rd_en = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_entry_count <= '0;
            r_issue_on    <= 1'b0;
            r_rvalid      <= 1'b0;
            r_rlast       <= 1'b0;
            r_strobe      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= done || (query_go && (limit == '0));
            if (i_cfg_wr_en) begin
                r_entry_count <= i_cfg_wr_data;
            end
            // read issue
            if (query_go) begin
                r_issue_on <= 1'b1;
            end else if (done || (rd_en && (r_ptr == r_last_idx))) begin
                r_issue_on <= 1'b0;
            end
            r_rvalid <= rd_en && !done;
            r_rlast  <= rd_en && (r_ptr == r_last_idx);
        end
    end

    // Query capture and scan pointer
    always_ff @(posedge i_clk) begin
        if (query_go) begin
            r_key      <= query_key;
            r_strict   <= i_item.strict_match;
            r_ptr      <= '0;
            r_last_idx <= AW'(limit - LW'(1));
        end else if (rd_en) begin
            r_ptr <= r_ptr + AW'(1);
        end
        r_ridx <= r_ptr;
    end

    // Result register: zeros on a miss
    always_ff @(posedge i_clk) begin
        if (done && status.hit) begin
            r_result.found           <= 1'b1;
            r_result.match_slot      <= SLOT_W'(r_ridx);
            r_result.reversed        <= status.reversed;
            r_result.out_force_one   <= rd_data.force_one;
            r_result.out_force_two   <= rd_data.force_two;
            r_result.out_force_three <= rd_data.force_three;
        end else if (done || query_go) begin
            r_result <= '0;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== sv/tplu_table_ram.sv =====
// tplu_table_ram: entry memory, one write port and one registered read port.
// Depends on tplu_pkg for the entry type.
module tplu_table_ram
    import tplu_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/tplu_match.sv =====
// tplu_match: compares one stored key against the query in both atom orders.
// Depends on tplu_pkg for the key type and bond code helper.
module tplu_match
    import tplu_pkg::*;
(
    input  t_key          i_entry,
    input  t_key          i_query,
    input  logic          i_strict,
    output t_match_status o_status
);

    logic mid_ok;
    logic fwd_ok;
    logic rev_ok;

    // Outer atom: equal, or entry wildcard when not strict
    function automatic logic outer_fits(input logic [ATOM_W-1:0] ent,
                                        input logic [ATOM_W-1:0] q,
                                        input logic strict);
        return (ent == q) || (!strict && (ent == WILDCARD_TYPE));
    endfunction

    always_comb begin
        mid_ok = bond_code(i_entry.bonds, 1) == bond_code(i_query.bonds, 1);

        // forward: a,b,c,d with bonds first,third
        fwd_ok = (bond_code(i_entry.bonds, 0) == bond_code(i_query.bonds, 0))
              && (bond_code(i_entry.bonds, 2) == bond_code(i_query.bonds, 2))
              && (i_entry.atom_b == i_query.atom_b)
              && (i_entry.atom_c == i_query.atom_c)
              && outer_fits(i_entry.atom_a, i_query.atom_a, i_strict)
              && outer_fits(i_entry.atom_d, i_query.atom_d, i_strict);

        // reversed: d,c,b,a with bonds third,first
        rev_ok = (bond_code(i_entry.bonds, 0) == bond_code(i_query.bonds, 2))
              && (bond_code(i_entry.bonds, 2) == bond_code(i_query.bonds, 0))
              && (i_entry.atom_b == i_query.atom_c)
              && (i_entry.atom_c == i_query.atom_b)
              && outer_fits(i_entry.atom_a, i_query.atom_d, i_strict)
              && outer_fits(i_entry.atom_d, i_query.atom_a, i_strict);

        o_status.hit      = mid_ok && (fwd_ok || rev_ok);
        o_status.reversed = !fwd_ok;
    end

endmodule

// ===== sv/tplu_checker.sv =====
// tplu_checker: port-level assertions for the torsion lookup, bound to the top.
// Depends on tplu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tplu_checker
    import tplu_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input t_query_word        i_item,
    input logic               o_strobe,
    input t_result_word       o_result
);

    logic take_query;
    logic take_write;
    logic miss_clean;

    assign take_query = start && !busy && (i_item.func == FUNC_QUERY);
    assign take_write = start && !busy && (i_item.func == FUNC_WRITE);

    // Everything but found is zero
    assign miss_clean = (o_result.match_slot == '0) && !o_result.reversed
                     && (o_result.out_force_one == '0) && (o_result.out_force_two == '0)
                     && (o_result.out_force_three == '0);

    // A miss word carries nothing but zeros
    `AST_SAME(a_miss_zero, i_clk, i_rst_n, o_strobe && !o_result.found, miss_clean)

    // A result only shows once the scan has released the block
    `AST_SAME(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy)

    // A query either starts a scan or answers at once
    `AST_NEXT(a_query_reacts, i_clk, i_rst_n, take_query, busy || o_strobe)

    // A write gives no result and leaves the block free
    `AST_NEXT(a_write_silent, i_clk, i_rst_n, take_write, !busy && !o_strobe)

endmodule

bind torsion_param_lookup_unit tplu_checker u_tplu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_item        (i_item),
    .o_strobe      (o_strobe),
    .o_result      (o_result)
);
